// File: src/utf8cw_pkg.sv
`timescale 1ns / 1ps

package utf8cw_pkg;

    // Counter width of the running totals; outputs are always 16 bits.
    localparam int COUNT_BITS  = 16;
    localparam int CNT_W       = COUNT_BITS;
    localparam int OUT_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CODE_W      = 21;
    localparam int CMP_W       = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int INC_W       = 4;

    localparam logic [CFG_W-1:0] COL_LIMIT_RESET = 16'd80;

    // Register index decoded from the word address.
    typedef enum logic [0:0] {
        REG_COL_LIMIT = 1'b0
    } reg_idx_t;

    // One decoded step: flushed single-byte characters first, then at most
    // one whole character.
    typedef struct packed {
        logic [2:0] singles;
        logic       has_char;
        logic [2:0] char_bytes;
        logic [1:0] char_width;
        logic       last;
    } tok_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [1:0] glyph_width(input logic [CODE_W-1:0] c);
        logic [1:0] w;
        begin
            w = 2'd1;
            if (c < 21'h20 || (c >= 21'h7f && c < 21'ha0))
            begin
                w = 2'd0;
            end
            else if ((c >= 21'h0300 && c <= 21'h036f) || (c >= 21'h1ab0 && c <= 21'h1aff) ||
                     (c >= 21'h1dc0 && c <= 21'h1dff) || (c >= 21'h20d0 && c <= 21'h20ff) ||
                     c == 21'h200b)
            begin
                w = 2'd0;
            end
            else if ((c >= 21'h1100 && c <= 21'h115f) || (c >= 21'h2e80 && c <= 21'h303e) ||
                     (c >= 21'h3041 && c <= 21'h33ff) || (c >= 21'h3400 && c <= 21'h4dbf) ||
                     (c >= 21'h4e00 && c <= 21'h9fff) || (c >= 21'ha000 && c <= 21'ha4cf) ||
                     (c >= 21'hac00 && c <= 21'hd7a3) || (c >= 21'hf900 && c <= 21'hfaff) ||
                     (c >= 21'hfe30 && c <= 21'hfe4f) || (c >= 21'hff00 && c <= 21'hff60) ||
                     (c >= 21'hffe0 && c <= 21'hffe6) ||
                     (c >= 21'h20000 && c <= 21'h3fffd))
            begin
                w = 2'd2;
            end
            return w;
        end
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [INC_W-1:0] b);
        logic [CNT_W:0] s;
        begin
            s = {1'b0, a} + (CNT_W+1)'(b);
            return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
        end
    endfunction

endpackage

// File: src/utf8cw_front.sv
`timescale 1ns / 1ps

module utf8cw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        byte_in,
    input  logic              last,
    input  utf8cw_pkg::q_stat_t q_stat,
    output logic              push,
    output utf8cw_pkg::tok_t  push_tok
);
    import utf8cw_pkg::*;

    logic [1:0]        needed_reg, needed_next;
    logic [2:0]        held_reg, held_next;
    logic [CODE_W-1:0] accum_reg, accum_next;
    logic              ended_reg, ended_next;
    logic              accept;
    logic              is_cont;
    logic [CODE_W-1:0] accum_ext;
    tok_t              tok;

    assign in_ready  = !q_stat.full;
    assign accept    = in_valid && in_ready;
    assign push      = accept;
    assign push_tok  = tok;
    assign is_cont   = (byte_in[7:6] == 2'b10);
    assign accum_ext = {accum_reg[CODE_W-7:0], byte_in[5:0]};

    always_comb
    begin
        needed_next = needed_reg;
        held_next   = held_reg;
        accum_next  = accum_reg;
        ended_next  = ended_reg;
        tok         = '0;
        tok.last    = last;
        if (!ended_reg)
        begin
            if (byte_in == 8'd0)
            begin
                // A zero byte flushes any open sequence and ends the string.
                tok.singles = held_reg;
                needed_next = 2'd0;
                held_next   = 3'd0;
                accum_next  = '0;
                ended_next  = 1'b1;
            end
            else if (needed_reg != 2'd0 && is_cont)
            begin
                accum_next  = accum_ext;
                held_next   = held_reg + 3'd1;
                needed_next = needed_reg - 2'd1;
                if (needed_reg == 2'd1)
                begin
                    tok.has_char   = 1'b1;
                    tok.char_bytes = held_reg + 3'd1;
                    tok.char_width = glyph_width(accum_ext);
                    held_next      = 3'd0;
                    accum_next     = '0;
                end
            end
            else
            begin
                // Any held bytes of a broken sequence go out as single columns.
                tok.singles = held_reg;
                needed_next = 2'd0;
                held_next   = 3'd0;
                accum_next  = '0;
                priority if (byte_in[7] == 1'b0)
                begin
                    tok.has_char   = 1'b1;
                    tok.char_bytes = 3'd1;
                    tok.char_width = glyph_width(CODE_W'(byte_in));
                end
                else if (byte_in[7:5] == 3'b110)
                begin
                    accum_next  = CODE_W'(byte_in[4:0]);
                    needed_next = 2'd1;
                    held_next   = 3'd1;
                end
                else if (byte_in[7:4] == 4'b1110)
                begin
                    accum_next  = CODE_W'(byte_in[3:0]);
                    needed_next = 2'd2;
                    held_next   = 3'd1;
                end
                else if (byte_in[7:3] == 5'b11110)
                begin
                    accum_next  = CODE_W'(byte_in[2:0]);
                    needed_next = 2'd3;
                    held_next   = 3'd1;
                end
                else
                begin
                    tok.has_char   = 1'b1;
                    tok.char_bytes = 3'd1;
                    tok.char_width = 2'd1;
                end
            end
        end
        if (last)
        begin
            // A sequence still open at the end is flushed; the string restarts.
            tok.singles = tok.singles + held_next;
            needed_next = 2'd0;
            held_next   = 3'd0;
            accum_next  = '0;
            ended_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg <= 2'd0;
            held_reg   <= 3'd0;
            accum_reg  <= '0;
            ended_reg  <= 1'b0;
        end
        else if (accept)
        begin
            needed_reg <= needed_next;
            held_reg   <= held_next;
            accum_reg  <= accum_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

// File: src/utf8cw_queue.sv
`timescale 1ns / 1ps

module utf8cw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  utf8cw_pkg::tok_t    push_tok,
    input  logic                pop,
    output utf8cw_pkg::tok_t    pop_tok,
    output utf8cw_pkg::q_stat_t q_stat
);
    import utf8cw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    tok_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_tok      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/utf8cw_back.sv
`timescale 1ns / 1ps

module utf8cw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  utf8cw_pkg::q_stat_t           q_stat,
    input  utf8cw_pkg::tok_t              pop_tok,
    output logic                          pop,
    input  logic [utf8cw_pkg::CFG_W-1:0]  column_limit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [utf8cw_pkg::OUT_W-1:0]  total_columns,
    output logic [utf8cw_pkg::OUT_W-1:0]  fit_bytes,
    output logic [utf8cw_pkg::OUT_W-1:0]  fit_columns
);
    import utf8cw_pkg::*;

    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] pbytes_reg, pbytes_next;
    logic [CNT_W-1:0] pcols_reg, pcols_next;
    logic             closed_reg, closed_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] total_out_reg, bytes_out_reg, cols_out_reg;

    logic [CMP_W-1:0] lim, pc, pc1, room;
    logic [2:0]       joined;
    logic             closed1, fits;
    logic [CNT_W-1:0] pcols1;
    logic [INC_W-1:0] byte_inc, col_inc;

    assign pop = !q_stat.empty && (!pop_tok.last || !out_valid_reg || out_ready);

    always_comb
    begin
        lim  = CMP_W'(column_limit);
        pc   = CMP_W'(pcols_reg);
        room = lim - pc;
        // Flushed bytes each take one column; they join until the limit is hit.
        if (closed_reg || column_limit == '0 || pc >= lim)
        begin
            joined = 3'd0;
        end
        else if (CMP_W'(pop_tok.singles) <= room)
        begin
            joined = pop_tok.singles;
        end
        else
        begin
            joined = room[2:0];
        end
        closed1 = closed_reg || (joined != pop_tok.singles);
        pcols1  = sat_add(pcols_reg, INC_W'(joined));
        pc1     = CMP_W'(pcols1);
        fits    = pop_tok.has_char && !closed1 && (column_limit != '0) &&
                  (pc1 + CMP_W'(pop_tok.char_width) <= lim);

        byte_inc = INC_W'(joined) + (fits ? INC_W'(pop_tok.char_bytes) : '0);
        col_inc  = INC_W'(pop_tok.singles) +
                   (pop_tok.has_char ? INC_W'(pop_tok.char_width) : '0);

        total_next  = sat_add(total_reg, col_inc);
        pbytes_next = sat_add(pbytes_reg, byte_inc);
        pcols_next  = fits ? sat_add(pcols1, INC_W'(pop_tok.char_width)) : pcols1;
        closed_next = closed1 || (pop_tok.has_char && !fits);

        if (pop && pop_tok.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            pbytes_reg    <= '0;
            pcols_reg     <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                if (pop_tok.last)
                begin
                    total_reg  <= '0;
                    pbytes_reg <= '0;
                    pcols_reg  <= '0;
                    closed_reg <= 1'b0;
                end
                else
                begin
                    total_reg  <= total_next;
                    pbytes_reg <= pbytes_next;
                    pcols_reg  <= pcols_next;
                    closed_reg <= closed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_tok.last)
        begin
            total_out_reg <= OUT_W'(total_next);
            bytes_out_reg <= OUT_W'(pbytes_next);
            cols_out_reg  <= OUT_W'(pcols_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign total_columns = total_out_reg;
    assign fit_bytes     = bytes_out_reg;
    assign fit_columns   = cols_out_reg;

endmodule

// File: src/utf8_column_width_truncate.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload                                   Direction
// -------   ---------------------   ---------------------------------------   ---------
// input     in_valid / in_ready     byte_in[7:0], last                        in
// output    out_valid / out_ready   total_columns, fit_bytes, fit_columns     out
// config    psel/penable/pwrite     paddr[2:0], pwdata, prdata, pready        in/out
//
// One byte is taken every cycle while the queue is not full. A byte is decoded in the
// front in the cycle of its transfer, its token enters a two-entry queue, and the back
// pops it from there; a string's result is registered as its last-byte token is popped.
// Reset clears all string state and sets the column limit to 80; there is no clearing pass.
// A result waits in the output register while out_ready is low; the back then stalls
// only on the next last-byte token, and in_ready drops once the queue is full.
module utf8_column_width_truncate (
    input  logic        clk,
    input  logic        rst_n,
    // byte stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        last,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] total_columns,
    output logic [15:0] fit_bytes,
    output logic [15:0] fit_columns,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import utf8cw_pkg::*;

    logic [CFG_W-1:0] col_limit_reg;
    logic             cfg_write;
    logic             push;
    logic             pop;
    tok_t             push_tok;
    tok_t             pop_tok;
    q_stat_t          q_stat;

    // The register file is a single word; address bit 2 selects the register and
    // the byte offset bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_COL_LIMIT);
    assign prdata    = (paddr[2] == REG_COL_LIMIT) ? 32'(col_limit_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_limit_reg <= COL_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            col_limit_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Front: UTF-8 sequence decoding and width classification.
    utf8cw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .byte_in  (byte_in),
        .last     (last),
        .q_stat   (q_stat),
        .push     (push),
        .push_tok (push_tok)
    );

    // Token queue between decode and accumulation.
    utf8cw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .pop_tok  (pop_tok),
        .q_stat   (q_stat)
    );

    // Back: saturating totals, prefix fit and the result register.
    utf8cw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_tok       (pop_tok),
        .pop           (pop),
        .column_limit  (col_limit_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .total_columns (total_columns),
        .fit_bytes     (fit_bytes),
        .fit_columns   (fit_columns)
    );

    // The back never takes a token from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("token popped from an empty queue");

    // A new result only appears after the back took a last-byte token.
    assert property (@(posedge clk) disable iff (!rst_n)
                     $rose(out_valid) |-> $past(pop && pop_tok.last))
        else $error("result shown without a last-byte token");

    // The fitting prefix is never wider than the whole string.
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_valid |-> (fit_columns <= total_columns))
        else $error("prefix width exceeds total width");

endmodule

// File: verif/tb_utf8_column_width_truncate.sv
`timescale 1ns / 1ps

// Self-checking bench for the UTF-8 display width / truncation block.
//
// Bytes go in on a valid/ready channel and one width report per string comes out on
// another. A behavioral predictor below tracks the decode state and the counters for
// every accepted byte; each report the block produces is checked against the oldest
// expectation, field by field. The bench walks a short directed table first, then six
// phases of random strings, each under its own column limit, two per idling mode.
module tb_utf8_column_width_truncate;

    import utf8cw_pkg::*;

    // One width report as the block presents it.
    typedef struct packed {
        logic [15:0] total;
        logic [15:0] fbytes;
        logic [15:0] fcols;
    } width_report_t;

    // A row of the directed table. When pinned is set, the report typed into the row
    // is the expectation; otherwise the predictor supplies it.
    typedef struct packed {
        logic [7:0]    data;
        logic          fin;
        logic          pinned;
        width_report_t rep;
    } dir_row_t;

    // A codepoint span with a fixed display width.
    typedef struct packed {
        logic [20:0] lo;
        logic [20:0] hi;
        logic [1:0]  cols;
    } span_t;

    localparam int N_SPANS     = 19;
    localparam int DIR_N       = 25;
    // Extra wait in quiesce after the last report, to let the queue and output register drain.
    localparam int SETTLE      = 8;
    // Longer than any sender gap, receiver stall or hold-off this bench creates.
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_BYTES = 210;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in     = 8'h00;
    logic        last        = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [15:0] total_columns;
    logic [15:0] fit_bytes;
    logic [15:0] fit_columns;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Travels with the payload so the monitor sees the pin of the byte it accepts.
    logic          row_pinned = 1'b0;
    width_report_t row_report = '0;

    utf8_column_width_truncate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .total_columns (total_columns),
        .fit_bytes     (fit_bytes),
        .fit_columns   (fit_columns),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor state. The column limit is copied here whenever the bench
    // writes the register, which only happens while nothing is in flight.
    // ------------------------------------------------------------------
    logic [15:0] col_limit  = 16'd80;
    logic [1:0]  pend_cont  = '0;
    logic [2:0]  held_n     = '0;
    logic [20:0] cp_acc     = '0;
    logic [15:0] run_cols   = '0;
    logic [15:0] fit_b      = '0;
    logic [15:0] fit_c      = '0;
    logic        fit_done   = 1'b0;
    logic        str_over   = 1'b0;

    width_report_t widths_due[$];
    int            mismatches     = 0;
    int            send_gap_pct   = 0;
    int            recv_stall_pct = 0;
    bit            hold_req       = 1'b0;
    int            live_bytes     = 0;
    logic [7:0]    str_bytes[$];

    // Zero-width spans come first, then the East Asian wide and fullwidth spans.
    // Everything outside these spans is one column.
    function automatic span_t span_at(input int k);
        span_t s;
        begin
            case (k)
                0:       s = {21'h00000, 21'h0001f, 2'd0};
                1:       s = {21'h0007f, 21'h0009f, 2'd0};
                2:       s = {21'h00300, 21'h0036f, 2'd0};
                3:       s = {21'h01ab0, 21'h01aff, 2'd0};
                4:       s = {21'h01dc0, 21'h01dff, 2'd0};
                5:       s = {21'h020d0, 21'h020ff, 2'd0};
                6:       s = {21'h0200b, 21'h0200b, 2'd0};
                7:       s = {21'h01100, 21'h0115f, 2'd2};
                8:       s = {21'h02e80, 21'h0303e, 2'd2};
                9:       s = {21'h03041, 21'h033ff, 2'd2};
                10:      s = {21'h03400, 21'h04dbf, 2'd2};
                11:      s = {21'h04e00, 21'h09fff, 2'd2};
                12:      s = {21'h0a000, 21'h0a4cf, 2'd2};
                13:      s = {21'h0ac00, 21'h0d7a3, 2'd2};
                14:      s = {21'h0f900, 21'h0faff, 2'd2};
                15:      s = {21'h0fe30, 21'h0fe4f, 2'd2};
                16:      s = {21'h0ff00, 21'h0ff60, 2'd2};
                17:      s = {21'h0ffe0, 21'h0ffe6, 2'd2};
                default: s = {21'h20000, 21'h3fffd, 2'd2};
            endcase
            return s;
        end
    endfunction

    function automatic logic [1:0] glyph_cols(input logic [20:0] cp);
        logic [1:0] w;
        span_t      s;
        begin
            w = 2'd1;
            for (int k = 0; k < N_SPANS; k++)
            begin
                s = span_at(k);
                if (cp >= s.lo && cp <= s.hi)
                begin
                    w = s.cols;
                end
            end
            return w;
        end
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [2:0] inc);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {14'd0, inc};
            return s[16] ? 16'hffff : s[15:0];
        end
    endfunction

    // One finished character of nb bytes and w columns. The total always grows; the
    // prefix grows only until the first character that does not fit, and then stays.
    task automatic take_char(input logic [2:0] nb, input logic [1:0] w);
        begin
            run_cols = sat16(run_cols, {1'b0, w});
            if (!fit_done)
            begin
                if (col_limit == 16'd0 || ({1'b0, fit_c} + {15'd0, w}) > {1'b0, col_limit})
                begin
                    fit_done = 1'b1;
                end
                else
                begin
                    fit_c = sat16(fit_c, {1'b0, w});
                    fit_b = sat16(fit_b, nb);
                end
            end
        end
    endtask

    // Bytes of an unfinished sequence each count as a one-column character.
    task automatic dump_held();
        begin
            for (int i = 0; i < held_n; i++)
            begin
                take_char(3'd1, 2'd1);
            end
            held_n    = '0;
            pend_cont = '0;
            cp_acc    = '0;
        end
    endtask

    task automatic open_seq(input logic [7:0] b);
        begin
            if (!b[7])
            begin
                take_char(3'd1, glyph_cols({13'd0, b}));
            end
            else if (b[7:5] == 3'b110)
            begin
                cp_acc    = {16'd0, b[4:0]};
                pend_cont = 2'd1;
                held_n    = 3'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_acc    = {17'd0, b[3:0]};
                pend_cont = 2'd2;
                held_n    = 3'd1;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_acc    = {18'd0, b[2:0]};
                pend_cont = 2'd3;
                held_n    = 3'd1;
            end
            else
            begin
                // Stray continuation or a lead in F8..FF.
                take_char(3'd1, 2'd1);
            end
        end
    endtask

    // Advances the width measurement by one accepted byte. On the byte marked last it
    // hands back the report of the string and starts a fresh one.
    task automatic measure_byte(input logic [7:0] b, input logic fin,
                                output logic made, output width_report_t rep);
        begin
            made = 1'b0;
            rep  = '0;
            if (!str_over)
            begin
                if (b == 8'h00)
                begin
                    dump_held();
                    str_over = 1'b1;
                end
                else if (pend_cont != 2'd0)
                begin
                    if (b[7:6] == 2'b10)
                    begin
                        cp_acc    = {cp_acc[14:0], b[5:0]};
                        held_n    = held_n + 3'd1;
                        pend_cont = pend_cont - 2'd1;
                        if (pend_cont == 2'd0)
                        begin
                            take_char(held_n, glyph_cols(cp_acc));
                            held_n = '0;
                            cp_acc = '0;
                        end
                    end
                    else
                    begin
                        dump_held();
                        open_seq(b);
                    end
                end
                else
                begin
                    open_seq(b);
                end
            end
            if (fin)
            begin
                dump_held();
                made       = 1'b1;
                rep.total  = run_cols;
                rep.fbytes = fit_b;
                rep.fcols  = fit_c;
                run_cols   = '0;
                fit_b      = '0;
                fit_c      = '0;
                fit_done   = 1'b0;
                str_over   = 1'b0;
            end
        end
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
        begin
            if (got !== want)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                mismatches++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge, where every
    // bench-driven signal still holds the value it had before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic          made;
        width_report_t calc;
        width_report_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                measure_byte(byte_in, last, made, calc);
                if (made)
                begin
                    widths_due.push_back(row_pinned ? row_report : calc);
                end
            end
            if (out_valid && out_ready)
            begin
                if (widths_due.size() == 0)
                begin
                    $display("%0t: report with none expected: total %0d bytes %0d cols %0d",
                             $time, total_columns, fit_bytes, fit_columns);
                    mismatches++;
                end
                else
                begin
                    want = widths_due.pop_front();
                    cmp_field("total_columns", want.total, total_columns);
                    cmp_field("fit_bytes", want.fbytes, fit_bytes);
                    cmp_field("fit_columns", want.fcols, fit_columns);
                end
            end
        end
    end

    // Watchdog: a run of cycles without any transfer on either channel means a hang.
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver. It stalls at random, and on request it holds ready low for a long
    // stretch so the block backs up and pushes back on the byte stream.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one byte and returns at the edge of its transfer. A gap is opened only
    // by lowering valid here, so valid is never lowered and raised in one step.
    task automatic send(input logic [7:0] b, input logic fin, input logic pinned,
                        input width_report_t rep);
        begin
            if ($urandom_range(99) < send_gap_pct)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
            end
            in_valid   <= 1'b1;
            byte_in    <= b;
            last       <= fin;
            row_pinned <= pinned;
            row_report <= rep;
            do @(posedge clk); while (!in_ready);
        end
    endtask

    // Stops the stream and waits until every report is back and the pipeline is empty.
    task automatic quiesce();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (widths_due.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    // Writes the column limit, then reads it back in a back-to-back transfer.
    task automatic write_limit(input logic [15:0] v);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_COL_LIMIT, 2'b00};
            pwdata  <= {16'd0, v};
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            col_limit = v;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata[15:0] !== v)
            begin
                $display("%0t: column limit read expected %0d got %0d", $time, v,
                         prdata[15:0]);
                mismatches++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    function automatic int code_len(input logic [20:0] cp);
        begin
            if (cp < 21'h80)
            begin
                return 1;
            end
            else if (cp < 21'h800)
            begin
                return 2;
            end
            else if (cp < 21'h10000)
            begin
                return 3;
            end
            return 4;
        end
    endfunction

    // Appends the nb-byte form of cp to the string, keeping only its first keep bytes.
    // An nb longer than needed gives an overlong form.
    task automatic pack_code(input logic [20:0] cp, input int nb, input int keep);
        logic [7:0] e[4];
        begin
            case (nb)
                1:
                begin
                    e[0] = {1'b0, cp[6:0]};
                end
                2:
                begin
                    e[0] = {3'b110, cp[10:6]};
                    e[1] = {2'b10, cp[5:0]};
                end
                3:
                begin
                    e[0] = {4'b1110, cp[15:12]};
                    e[1] = {2'b10, cp[11:6]};
                    e[2] = {2'b10, cp[5:0]};
                end
                default:
                begin
                    e[0] = {5'b11110, cp[20:18]};
                    e[1] = {2'b10, cp[17:12]};
                    e[2] = {2'b10, cp[11:6]};
                    e[3] = {2'b10, cp[5:0]};
                end
            endcase
            for (int i = 0; i < keep; i++)
            begin
                str_bytes.push_back(e[i]);
            end
        end
    endtask

    // One random character. Roughly three quarters are well formed, with extra weight
    // on the edges of every width span; the rest are broken or stray bytes and zeros.
    task automatic add_random_char();
        int         pick;
        int         nb;
        logic [20:0] cp;
        span_t      s;
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                str_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
            end
            else if (pick < 30)
            begin
                str_bytes.push_back($urandom_range(1) ? 8'h7f : 8'($urandom_range(1, 31)));
            end
            else if (pick < 50)
            begin
                s  = span_at($urandom_range(N_SPANS - 1));
                cp = $urandom_range(1) ? s.lo : s.hi;
                case ($urandom_range(2))
                    0:       cp = cp - 21'd1;
                    1:       cp = cp + 21'd1;
                    default: cp = cp;
                endcase
                if (cp == 21'd0)
                begin
                    cp = 21'd1;
                end
                pack_code(cp, code_len(cp), code_len(cp));
            end
            else if (pick < 65)
            begin
                nb = $urandom_range(2, 4);
                case (nb)
                    2:       cp = 21'($urandom_range(21'h80, 21'h7ff));
                    3:       cp = 21'($urandom_range(21'h800, 21'hffff));
                    default: cp = 21'($urandom_range(21'h10000, 21'h1fffff));
                endcase
                pack_code(cp, nb, nb);
            end
            else if (pick < 70)
            begin
                // Overlong form of an ASCII value.
                nb = $urandom_range(2, 4);
                pack_code(21'($urandom_range(0, 21'h7f)), nb, nb);
            end
            else if (pick < 75)
            begin
                pack_code(21'($urandom_range(21'h20000, 21'h3fffd)), 4, 4);
            end
            else if (pick < 80)
            begin
                str_bytes.push_back(8'($urandom_range(8'hf8, 8'hff)));
            end
            else if (pick < 85)
            begin
                str_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
            end
            else if (pick < 93)
            begin
                // Sequence cut short; whatever comes next breaks or extends it.
                nb = $urandom_range(2, 4);
                pack_code(21'($urandom), nb, $urandom_range(1, nb - 1));
            end
            else if (pick < 96)
            begin
                // Terminating zero followed by bytes the block must ignore.
                str_bytes.push_back(8'h00);
                repeat ($urandom_range(0, 3)) str_bytes.push_back(8'($urandom_range(1, 255)));
            end
            else
            begin
                str_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
    endtask

    // Builds a random string and sends it, with last on its final byte. Mostly short
    // strings; some long ones so that small limits truncate the prefix.
    task automatic send_string();
        int n;
        bit dead;
        begin
            str_bytes.delete();
            dead = 1'b0;
            n = ($urandom_range(4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            repeat (n) add_random_char();
            for (int i = 0; i < str_bytes.size(); i++)
            begin
                if (str_bytes[i] == 8'h00)
                begin
                    dead = 1'b1;
                end
                if (!dead)
                begin
                    live_bytes++;
                end
                send(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
            end
        end
    endtask

    // Directed strings under the reset limit of 80 columns. Rows without a typed
    // report are checked against the predictor.
    dir_row_t dir_rows [DIR_N] = '{
        // printable character, one column
        {8'h41, 1'b1, 1'b1, 16'd1, 16'd1, 16'd1},
        // a zero byte alone is an empty string
        {8'h00, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0},
        // control character: no width, but it still joins the prefix
        {8'h7f, 1'b1, 1'b1, 16'd0, 16'd1, 16'd0},
        // invalid lead byte
        {8'hff, 1'b1, 1'b1, 16'd1, 16'd1, 16'd1},
        // stray continuation byte
        {8'h80, 1'b1, 1'b1, 16'd1, 16'd1, 16'd1},
        // CJK ideograph, three bytes, two columns
        {8'he4, 1'b0, 1'b0, 48'd0},
        {8'hb8, 1'b0, 1'b0, 48'd0},
        {8'h80, 1'b1, 1'b0, 48'd0},
        // supplementary ideograph, four bytes
        {8'hf0, 1'b0, 1'b0, 48'd0},
        {8'ha0, 1'b0, 1'b0, 48'd0},
        {8'h80, 1'b0, 1'b0, 48'd0},
        {8'h80, 1'b1, 1'b0, 48'd0},
        // combining mark
        {8'hcc, 1'b0, 1'b0, 48'd0},
        {8'h80, 1'b1, 1'b0, 48'd0},
        // sequence broken by an ASCII byte: the held lead counts one column
        {8'he4, 1'b0, 1'b0, 48'd0},
        {8'h41, 1'b1, 1'b1, 16'd2, 16'd2, 16'd2},
        // sequence still open at the end of the string
        {8'hf0, 1'b0, 1'b0, 48'd0},
        {8'h9f, 1'b1, 1'b1, 16'd2, 16'd2, 16'd2},
        // bytes after a zero byte are ignored
        {8'h41, 1'b0, 1'b0, 48'd0},
        {8'h00, 1'b0, 1'b0, 48'd0},
        {8'hff, 1'b1, 1'b1, 16'd1, 16'd1, 16'd1},
        // value above the Unicode range is decoded leniently
        {8'hf7, 1'b0, 1'b0, 48'd0},
        {8'hbf, 1'b0, 1'b0, 48'd0},
        {8'hbf, 1'b0, 1'b0, 48'd0},
        {8'hbf, 1'b1, 1'b0, 48'd0}
    };

    initial
    begin : stimulus
        logic [15:0] lim;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 9;
        recv_stall_pct = 63;
        for (int r = 0; r < DIR_N; r++)
        begin
            send(dir_rows[r].data, dir_rows[r].fin, dir_rows[r].pinned, dir_rows[r].rep);
        end

        // Random phases: two limits per idling mode. The first mode idles the sender
        // lightly and the receiver heavily, the second the reverse, the last neither.
        for (int ph = 0; ph < 6; ph++)
        begin
            quiesce();
            case (ph / 2)
                0:
                begin
                    send_gap_pct   = 9;
                    recv_stall_pct = 63;
                end
                1:
                begin
                    send_gap_pct   = 63;
                    recv_stall_pct = 9;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (ph)
                0:       lim = 16'd0;
                1:       lim = 16'd12;
                2:       lim = 16'd1;
                3:       lim = 16'($urandom_range(2, 40));
                4:       lim = 16'hffff;
                default: lim = 16'($urandom_range(0, 65535));
            endcase
            write_limit(lim);
            if (ph == 4)
            begin
                // Long hold-off on the result side while bytes keep coming.
                hold_req = 1'b1;
            end
            live_bytes = 0;
            while (live_bytes < PHASE_BYTES)
            begin
                send_string();
            end
        end

        quiesce();
        if (mismatches == 0 && widths_due.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
